@@ src/bft_pkg.sv @@
// ----------------------------------------------------------------------------
// bft_pkg
// Shared constants and types of the forwarding table: sizes, operation codes
// and the item that travels along the row of table cells.
// ----------------------------------------------------------------------------
`default_nettype none

package bft_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MASK_BITS     = 64;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // done: lookup has hit, or add has been placed
    typedef struct packed {
        logic                 valid;
        logic [1:0]           op;
        logic [15:0]          id;
        logic                 done;
        logic [63:0]          prefix_hi;
        logic [63:0]          prefix_lo;
        logic [MASK_BITS-1:0] mask;
        logic [63:0]          hop_hi;
        logic [63:0]          hop_lo;
        logic [7:0]           port;
    } t_token;

endpackage

`default_nettype wire

@@ src/bft_if.sv @@
// ----------------------------------------------------------------------------
// bft_req_if / bft_rsp_if
// Valid/ready channels of the forwarding table: request items in, result
// items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bft_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] router_id;
    logic [63:0] prefix_in_hi;
    logic [63:0] prefix_in_lo;
    logic [63:0] mask_in;
    logic [63:0] hop_in_hi;
    logic [63:0] hop_in_lo;
    logic [7:0]  port_in;

    modport source (
        output valid, operation, router_id, prefix_in_hi, prefix_in_lo,
               mask_in, hop_in_hi, hop_in_lo, port_in,
        input  ready
    );
    modport sink (
        input  valid, operation, router_id, prefix_in_hi, prefix_in_lo,
               mask_in, hop_in_hi, hop_in_lo, port_in,
        output ready
    );
endinterface

interface bft_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [63:0] prefix_out_hi;
    logic [63:0] prefix_out_lo;
    logic [63:0] mask_out;
    logic [63:0] hop_out_hi;
    logic [63:0] hop_out_lo;
    logic [7:0]  port_out;
    logic        table_full;

    modport source (
        output valid, hit, prefix_out_hi, prefix_out_lo, mask_out,
               hop_out_hi, hop_out_lo, port_out, table_full,
        input  ready
    );
    modport sink (
        input  valid, hit, prefix_out_hi, prefix_out_lo, mask_out,
               hop_out_hi, hop_out_lo, port_out, table_full,
        output ready
    );
endinterface

`default_nettype wire

@@ src/bft_cell.sv @@
// ----------------------------------------------------------------------------
// bft_cell
// One table slot plus one stage of the item chain. An item passing through
// deletes, places or looks up against this slot, then moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module bft_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire bft_pkg::t_token i_tok,
    output bft_pkg::t_token      o_tok
);

    logic                          r_valid;
    logic                          n_valid;
    logic [15:0]                   r_id;
    logic [63:0]                   r_prefix_hi;
    logic [63:0]                   r_prefix_lo;
    logic [bft_pkg::MASK_BITS-1:0] r_mask;
    logic [63:0]                   r_hop_hi;
    logic [63:0]                   r_hop_lo;
    logic [7:0]                    r_port;
    bft_pkg::t_token               r_tok;
    bft_pkg::t_token               n_tok;
    logic                          w_match;
    logic                          w_wr;

    assign w_match = r_valid && (r_id == i_tok.id);

    always_comb begin
        n_valid = r_valid;
        n_tok   = i_tok;
        w_wr    = 1'b0;
        if (i_tok.valid) begin
            case (i_tok.op)
                bft_pkg::OP_LOOKUP: begin
                    if (!i_tok.done && w_match) begin
                        n_tok.done      = 1'b1;
                        n_tok.prefix_hi = r_prefix_hi;
                        n_tok.prefix_lo = r_prefix_lo;
                        n_tok.mask      = r_mask;
                        n_tok.hop_hi    = r_hop_hi;
                        n_tok.hop_lo    = r_hop_lo;
                        n_tok.port      = r_port;
                    end
                end
                bft_pkg::OP_ADD: begin
                    if (w_match) begin
                        n_valid = 1'b0;
                    end
                    // slot is free once any same-id route is dropped
                    if (!i_tok.done && (!r_valid || w_match)) begin
                        n_valid    = 1'b1;
                        w_wr       = 1'b1;
                        n_tok.done = 1'b1;
                    end
                end
                bft_pkg::OP_DELETE: begin
                    if (w_match) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_wr) begin
            r_id        <= i_tok.id;
            r_prefix_hi <= i_tok.prefix_hi;
            r_prefix_lo <= i_tok.prefix_lo;
            r_mask      <= i_tok.mask;
            r_hop_hi    <= i_tok.hop_hi;
            r_hop_lo    <= i_tok.hop_lo;
            r_port      <= i_tok.port;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

@@ src/bier_forwarding_table_unit.sv @@
// ----------------------------------------------------------------------------
// bier_forwarding_table_unit
// Exact-match BIER route table built as a row of cells, one slot per cell.
//
//   channel  dir  payload
//   i_req    in   operation, router_id, prefix, mask, next hop, port
//   o_rsp    out  hit, prefix, mask, next hop, port, table_full
//
// Each item walks the row one cell per cycle but in a stall; its result is
// offered from the output register behind the register of the last cell.
// A new item may enter every cycle; one in flight sees all earlier ones.
// Reset clears the slot valid marks and the chain at once, no sweep, and
// holds i_req.ready low.
// A stalled result freezes the whole chain and holds i_req.ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module bier_forwarding_table_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bft_req_if.sink    i_req,
    bft_rsp_if.source  o_rsp
);

    bft_pkg::t_token w_tok [bft_pkg::TABLE_ENTRIES+1];
    bft_pkg::t_token w_head;
    bft_pkg::t_token w_last;
    logic            w_adv;

    logic            r_out_valid;
    logic            r_hit;
    logic            r_full;
    logic [63:0]     r_prefix_hi;
    logic [63:0]     r_prefix_lo;
    logic [63:0]     r_mask;
    logic [63:0]     r_hop_hi;
    logic [63:0]     r_hop_lo;
    logic [7:0]      r_port;
    logic            n_hit;
    logic            n_full;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_adv && i_rst_n;

    always_comb begin
        w_head.valid     = i_req.valid;
        w_head.op        = i_req.operation;
        w_head.id        = i_req.router_id;
        w_head.done      = 1'b0;
        w_head.prefix_hi = i_req.prefix_in_hi;
        w_head.prefix_lo = i_req.prefix_in_lo;
        w_head.mask      = i_req.mask_in[bft_pkg::MASK_BITS-1:0];
        w_head.hop_hi    = i_req.hop_in_hi;
        w_head.hop_lo    = i_req.hop_in_lo;
        w_head.port      = i_req.port_in;
    end

    assign w_tok[0] = w_head;

    for (genvar g = 0; g < bft_pkg::TABLE_ENTRIES; g++) begin : g_cell
        bft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last = w_tok[bft_pkg::TABLE_ENTRIES];
    assign n_hit  = w_last.done && (w_last.op == bft_pkg::OP_LOOKUP);
    assign n_full = !w_last.done && (w_last.op == bft_pkg::OP_ADD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit       <= n_hit;
            r_full      <= n_full;
            r_prefix_hi <= n_hit ? w_last.prefix_hi : 64'd0;
            r_prefix_lo <= n_hit ? w_last.prefix_lo : 64'd0;
            r_mask      <= n_hit ? 64'(w_last.mask) : 64'd0;
            r_hop_hi    <= n_hit ? w_last.hop_hi : 64'd0;
            r_hop_lo    <= n_hit ? w_last.hop_lo : 64'd0;
            r_port      <= n_hit ? w_last.port : 8'd0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.table_full    = r_full;
    assign o_rsp.prefix_out_hi = r_prefix_hi;
    assign o_rsp.prefix_out_lo = r_prefix_lo;
    assign o_rsp.mask_out      = r_mask;
    assign o_rsp.hop_out_hi    = r_hop_hi;
    assign o_rsp.hop_out_lo    = r_hop_lo;
    assign o_rsp.port_out      = r_port;

    a_hit_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.hit && o_rsp.table_full))
        else $error("hit and table_full both set");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("input taken while result stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.hit) |->
            (o_rsp.port_out == 8'd0 && o_rsp.mask_out == 64'd0 &&
             o_rsp.prefix_out_hi == 64'd0 && o_rsp.hop_out_lo == 64'd0))
        else $error("non-zero data on miss");

endmodule

`default_nettype wire
